// File: hw/rtl/slue_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes of the segment list update engine.
// Depends on nothing; every other file imports it.
package slue_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int ADDR_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = 7;
	localparam int TIME_W = 32;
	localparam int OP_W = 3;
	localparam int STATUS_W = 2;
	localparam int FIELDS_W = CNT_W + 2 * TIME_W;
	localparam int TDATA_W = ((FIELDS_W + 7) / 8) * 8;
	localparam int PAD_W = TDATA_W - FIELDS_W;
	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SEGMENTS);

	typedef enum logic [OP_W-1:0] {
		OP_MOVE        = 3'd0,
		OP_INSERT      = 3'd1,
		OP_INSERT_ANTI = 3'd2,
		OP_REMOVE      = 3'd3,
		OP_REMOVE_ANTI = 3'd4,
		OP_READ        = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RK_NONE  = 2'd0,
		RK_POS   = 2'd1,
		RK_SHIFT = 2'd2,
		RK_FIX   = 2'd3
	} rd_kind_t;

	typedef enum logic [2:0] {
		WK_NONE   = 3'd0,
		WK_MOVE   = 3'd1,
		WK_WRAP   = 3'd2,
		WK_ANTI_S = 3'd3,
		WK_ANTI_E = 3'd4,
		WK_COPY   = 3'd5,
		WK_COPY_E = 3'd6
	} wr_kind_t;

	typedef struct packed {
		logic     load_req;
		logic     idx_init;
		logic     idx_step;
		rd_kind_t rd_kind;
		wr_kind_t wr_kind;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		status_t         status;
		logic            cnt_zero;
		logic            cnt_one;
		logic            shift_more;
	} dp_stat_t;

endpackage

// File: hw/rtl/segment_list_update_engine.sv
`timescale 1ns / 1ps
// Top level of the segment list update engine: stream ports, field packing,
// and the slue_ctrl / slue_dpath pair. Depends on slue_pkg.
//
// Channel   Dir  tuser              tdata (lowest bit up)
// s_*       in   req_type [2:0]     position, start_time, end_time, one pad bit
// m_*       out  status [1:0]       count_after, read_start, read_end, one pad bit
//
// Move and read pass S_DECODE, then S_W_A or S_RD_POS, then S_FINISH; rejects skip to
// S_FINISH from S_DECODE. Insert, insert anti and the remove kinds add an S_SH_RD and
// S_SH_WR step per entry moved, set by the single read and write port of each memory.
// Reset clears the count; the memories are not cleared and need no clearing pass.
// A result waits in an output register while the next request is taken; the engine
// stalls only when a new result is ready and the previous one is still not taken.
module segment_list_update_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// req_type
	input  logic [slue_pkg::OP_W-1:0]            s_tuser,
	// position, start_time, end_time, pad
	input  logic [slue_pkg::TDATA_W-1:0]         s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// status
	output logic [slue_pkg::STATUS_W-1:0]        m_tuser,
	// count_after, read_start, read_end, pad
	output logic [slue_pkg::TDATA_W-1:0]         m_tdata
);
	import slue_pkg::*;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [CNT_W-1:0]  count_after;
	logic [TIME_W-1:0] read_start;
	logic [TIME_W-1:0] read_end;

	slue_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	slue_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (s_tuser),
		.position    (s_tdata[CNT_W-1:0]),
		.start_time  (s_tdata[CNT_W +: TIME_W]),
		.end_time    (s_tdata[CNT_W+TIME_W +: TIME_W]),
		.status      (m_tuser),
		.count_after (count_after),
		.read_start  (read_start),
		.read_end    (read_end)
	);

	assign m_tdata = {{PAD_W{1'b0}}, read_end, read_start, count_after};

endmodule

// File: hw/rtl/slue_dpath.sv
`timescale 1ns / 1ps
// Datapath: request registers, segment count, shift index, segment memories and
// result register. Driven by slue_ctrl through dp_cmd_t; depends on slue_pkg.
module slue_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  slue_pkg::dp_cmd_t              cmd,
	output slue_pkg::dp_stat_t             stat,
	input  logic [slue_pkg::OP_W-1:0]      req_type,
	input  logic [slue_pkg::CNT_W-1:0]     position,
	input  logic [slue_pkg::TIME_W-1:0]    start_time,
	input  logic [slue_pkg::TIME_W-1:0]    end_time,
	output logic [slue_pkg::STATUS_W-1:0]  status,
	output logic [slue_pkg::CNT_W-1:0]     count_after,
	output logic [slue_pkg::TIME_W-1:0]    read_start,
	output logic [slue_pkg::TIME_W-1:0]    read_end
);
	import slue_pkg::*;

	logic [OP_W-1:0]   op_q;
	logic [CNT_W-1:0]  pos_q;
	logic [TIME_W-1:0] ns_q;
	logic [TIME_W-1:0] ne_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [TIME_W-1:0] rd_s_q;
	logic [TIME_W-1:0] rd_e_q;
	logic [TIME_W-1:0] start_mem [MAX_SEGMENTS];
	logic [TIME_W-1:0] end_mem [MAX_SEGMENTS];

	logic [CNT_W:0]    pos_x;
	logic [CNT_W:0]    cnt_x;
	logic [CNT_W:0]    idx_x;
	logic [CNT_W-1:0]  pos_inc;
	logic              p_lt_n;
	logic              p_le_n;
	logic              full;
	logic              wrap;
	logic              shift_up;
	logic              done;
	status_t           st;
	logic [CNT_W-1:0]  idx_start;
	logic [CNT_W-1:0]  cnt_next;
	logic [CNT_W-1:0]  ra;
	logic              rd_en;
	logic [CNT_W-1:0]  wa;
	logic              we_s;
	logic              we_e;
	logic [TIME_W-1:0] wd_s;
	logic [TIME_W-1:0] wd_e;

	assign pos_x    = {1'b0, pos_q};
	assign cnt_x    = {1'b0, cnt_q};
	assign idx_x    = {1'b0, idx_q};
	assign pos_inc  = CNT_W'(pos_x + 1'b1);
	assign p_lt_n   = pos_q < cnt_q;
	assign p_le_n   = pos_q <= cnt_q;
	assign full     = cnt_q >= MAX_COUNT;
	assign wrap     = (pos_x + 1'b1) == cnt_x;
	assign shift_up = (op_q == OP_INSERT) || (op_q == OP_INSERT_ANTI);
	assign done     = st == ST_DONE;

	always_comb begin
		case (op_q)
			OP_MOVE, OP_REMOVE, OP_REMOVE_ANTI, OP_READ: begin
				st = p_lt_n ? ST_DONE : ST_BAD;
			end
			OP_INSERT: begin
				st = full ? ST_FULL : (p_le_n ? ST_DONE : ST_BAD);
			end
			OP_INSERT_ANTI: begin
				if (cnt_q == '0) begin
					st = ST_DONE;
				end else begin
					st = full ? ST_FULL : (p_lt_n ? ST_DONE : ST_BAD);
				end
			end
			default: begin
				st = ST_BAD;
			end
		endcase
	end

	always_comb begin
		stat.op         = op_q;
		stat.status     = st;
		stat.cnt_zero   = cnt_q == '0;
		stat.cnt_one    = cnt_q == CNT_W'(1);
		stat.shift_more = shift_up ? (idx_q > pos_q) : ((idx_x + 1'b1) < cnt_x);
	end

	always_comb begin
		case (op_q)
			OP_INSERT, OP_INSERT_ANTI: begin
				idx_start = cnt_q;
			end
			OP_REMOVE_ANTI: begin
				idx_start = wrap ? '0 : pos_inc;
			end
			default: begin
				idx_start = pos_q;
			end
		endcase
	end

	always_comb begin
		cnt_next = cnt_q;
		if (done) begin
			if (shift_up) begin
				cnt_next = CNT_W'(cnt_x + 1'b1);
			end else if ((op_q == OP_REMOVE) || (op_q == OP_REMOVE_ANTI)) begin
				cnt_next = CNT_W'(cnt_x - 1'b1);
			end
		end
	end

	always_comb begin
		rd_en = 1'b1;
		case (cmd.rd_kind)
			RK_POS: begin
				ra = pos_q;
			end
			RK_SHIFT: begin
				ra = shift_up ? CNT_W'(idx_x - 1'b1) : CNT_W'(idx_x + 1'b1);
			end
			RK_FIX: begin
				ra = wrap ? '0 : pos_inc;
			end
			default: begin
				ra    = pos_q;
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wa   = pos_q;
		we_s = 1'b0;
		we_e = 1'b0;
		wd_s = rd_s_q;
		wd_e = rd_e_q;
		case (cmd.wr_kind)
			WK_MOVE: begin
				we_s = 1'b1;
				we_e = 1'b1;
				wd_s = ns_q;
				wd_e = ne_q;
			end
			WK_WRAP: begin
				wa   = '0;
				we_s = 1'b1;
				we_e = 1'b1;
				wd_s = ne_q;
				wd_e = ns_q;
			end
			WK_ANTI_S: begin
				wa   = pos_inc;
				we_s = 1'b1;
				wd_s = ne_q;
			end
			WK_ANTI_E: begin
				we_e = 1'b1;
				wd_e = ns_q;
			end
			WK_COPY: begin
				wa   = idx_q;
				we_s = 1'b1;
				we_e = 1'b1;
			end
			WK_COPY_E: begin
				wa   = wrap ? CNT_W'(cnt_x - 1'b1) : pos_q;
				we_e = 1'b1;
			end
			default: begin
				wa = pos_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_s) begin
			start_mem[wa[ADDR_W-1:0]] <= wd_s;
		end
		if (we_e) begin
			end_mem[wa[ADDR_W-1:0]] <= wd_e;
		end
		if (rd_en) begin
			rd_s_q <= start_mem[ra[ADDR_W-1:0]];
			rd_e_q <= end_mem[ra[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= req_type;
			pos_q <= position;
			ns_q  <= start_time;
			ne_q  <= end_time;
		end
		if (cmd.finish) begin
			status      <= st;
			count_after <= cnt_next;
			read_start  <= (done && (op_q == OP_READ)) ? rd_s_q : '0;
			read_end    <= (done && (op_q == OP_READ)) ? rd_e_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.finish) begin
				cnt_q <= cnt_next;
			end
			if (cmd.idx_init) begin
				idx_q <= idx_start;
			end else if (cmd.idx_step) begin
				idx_q <= shift_up ? CNT_W'(idx_x - 1'b1) : CNT_W'(idx_x + 1'b1);
			end
		end
	end

endmodule

// File: hw/rtl/slue_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences each request through read, copy and write steps and
// owns the handshakes. Drives slue_dpath; depends on slue_pkg.
module slue_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  slue_pkg::dp_stat_t  stat,
	output slue_pkg::dp_cmd_t   cmd
);
	import slue_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_RD_POS = 10'b00_0000_0100,
		S_FIX_RD = 10'b00_0000_1000,
		S_FIX_WR = 10'b00_0001_0000,
		S_SH_RD  = 10'b00_0010_0000,
		S_SH_WR  = 10'b00_0100_0000,
		S_W_A    = 10'b00_1000_0000,
		S_W_B    = 10'b01_0000_0000,
		S_FINISH = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign s_tready  = state_q == S_IDLE;
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load_req = s_tvalid;
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.idx_init = 1'b1;
				if (stat.status != ST_DONE) begin
					state_d = S_FINISH;
				end else begin
					case (stat.op)
						OP_MOVE: begin
							state_d = S_W_A;
						end
						OP_INSERT, OP_REMOVE: begin
							state_d = S_SH_RD;
						end
						OP_INSERT_ANTI: begin
							state_d = stat.cnt_zero ? S_W_A : S_SH_RD;
						end
						OP_REMOVE_ANTI: begin
							state_d = stat.cnt_one ? S_FINISH : S_FIX_RD;
						end
						OP_READ: begin
							state_d = S_RD_POS;
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_RD_POS: begin
				cmd.rd_kind = RK_POS;
				state_d     = S_FINISH;
			end
			S_FIX_RD: begin
				cmd.rd_kind = RK_FIX;
				state_d     = S_FIX_WR;
			end
			S_FIX_WR: begin
				cmd.wr_kind = WK_COPY_E;
				state_d     = S_SH_RD;
			end
			S_SH_RD: begin
				if (stat.shift_more) begin
					cmd.rd_kind = RK_SHIFT;
					state_d     = S_SH_WR;
				end else if ((stat.op == OP_INSERT) || (stat.op == OP_INSERT_ANTI)) begin
					state_d = S_W_A;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SH_WR: begin
				cmd.wr_kind  = WK_COPY;
				cmd.idx_step = 1'b1;
				state_d      = S_SH_RD;
			end
			S_W_A: begin
				if (stat.op == OP_INSERT_ANTI) begin
					if (stat.cnt_zero) begin
						cmd.wr_kind = WK_WRAP;
						state_d     = S_FINISH;
					end else begin
						cmd.wr_kind = WK_ANTI_S;
						state_d     = S_W_B;
					end
				end else begin
					cmd.wr_kind = WK_MOVE;
					state_d     = S_FINISH;
				end
			end
			S_W_B: begin
				cmd.wr_kind = WK_ANTI_E;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/slue_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the segment list update engine, bound to the top level.
// Depends on slue_pkg.
module slue_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [slue_pkg::OP_W-1:0]            s_tuser,
	input logic [slue_pkg::TDATA_W-1:0]         s_tdata,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [slue_pkg::STATUS_W-1:0]        m_tuser,
	input logic [slue_pkg::TDATA_W-1:0]         m_tdata
);
	import slue_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while a request is in progress");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CNT_W-1:0] <= MAX_COUNT))
		else $error("count exceeds list capacity");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_DONE)) |-> (m_tdata[FIELDS_W-1:CNT_W] == '0))
		else $error("rejected request returned read data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind segment_list_update_engine slue_checker u_slue_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the segment list update engine: it tracks the expected
// segment list per request and compares every result transfer. Depends on slue_pkg and the RTL.
module testbench;
	import slue_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int POS_MAX = 64;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int START_LSB = CNT_W;
	localparam int END_LSB = CNT_W + TIME_W;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  count_after;
		logic [TIME_W-1:0] read_start;
		logic [TIME_W-1:0] read_end;
	} seg_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OP_W-1:0] s_tuser = '0;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [STATUS_W-1:0] m_tuser;
	logic [TDATA_W-1:0] m_tdata;

	logic [TIME_W-1:0] seg_start [MAX_SEGMENTS];
	logic [TIME_W-1:0] seg_end [MAX_SEGMENTS];
	int model_count = 0;
	seg_result_t expected_q [$];

	bit idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int error_count = 0;
	int results_seen = 0;
	int sent_total = 0;
	int done_total = 0;
	int full_total = 0;
	int bad_total = 0;
	int peak_count = 0;

	segment_list_update_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic void open_slot(input int at, input int n);
		for (int i = n; i > at; i--) begin
			seg_start[i] = seg_start[i - 1];
			seg_end[i] = seg_end[i - 1];
		end
	endfunction

	function automatic void close_slot(input int at, input int n);
		for (int i = at; i + 1 < n; i++) begin
			seg_start[i] = seg_start[i + 1];
			seg_end[i] = seg_end[i + 1];
		end
	endfunction

	function automatic seg_result_t apply_request(input logic [OP_W-1:0] op,
			input logic [CNT_W-1:0] pos, input logic [TIME_W-1:0] t_start,
			input logic [TIME_W-1:0] t_end);
		seg_result_t r;
		int n;
		int p;
		n = model_count;
		p = pos;
		r.status = ST_DONE;
		r.read_start = '0;
		r.read_end = '0;
		case (op)
			OP_MOVE: begin
				if (p < n) begin
					seg_start[p] = t_start;
					seg_end[p] = t_end;
				end else
					r.status = ST_BAD;
			end
			OP_INSERT: begin
				if (n >= MAX_SEGMENTS)
					r.status = ST_FULL;
				else if (p > n)
					r.status = ST_BAD;
				else begin
					open_slot(p, n);
					seg_start[p] = t_start;
					seg_end[p] = t_end;
					model_count = n + 1;
				end
			end
			OP_INSERT_ANTI: begin
				if (n == 0) begin
					seg_start[0] = t_end;
					seg_end[0] = t_start;
					model_count = 1;
				end else if (n >= MAX_SEGMENTS)
					r.status = ST_FULL;
				else if (p >= n)
					r.status = ST_BAD;
				else begin
					open_slot(p, n);
					seg_start[p + 1] = t_end;
					seg_end[p] = t_start;
					model_count = n + 1;
				end
			end
			OP_REMOVE: begin
				if (p < n) begin
					close_slot(p, n);
					model_count = n - 1;
				end else
					r.status = ST_BAD;
			end
			OP_REMOVE_ANTI: begin
				if (p >= n)
					r.status = ST_BAD;
				else if (n == 1)
					model_count = 0;
				else if (p == n - 1) begin
					seg_end[n - 1] = seg_end[0];
					close_slot(0, n);
					model_count = n - 1;
				end else begin
					seg_end[p] = seg_end[p + 1];
					close_slot(p + 1, n);
					model_count = n - 1;
				end
			end
			OP_READ: begin
				if (p < n) begin
					r.read_start = seg_start[p];
					r.read_end = seg_end[p];
				end else
					r.status = ST_BAD;
			end
			default: r.status = ST_BAD;
		endcase
		r.count_after = CNT_W'(model_count);
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_position(input logic [OP_W-1:0] op, input int n);
		int top;
		top = (op == OP_INSERT) ? n : n - 1;
		if (top < 0)
			return CNT_W'($urandom_range(0, POS_MAX));
		case ($urandom_range(0, 3))
			0: return '0;
			1: return CNT_W'(top);
			default: return CNT_W'($urandom_range(0, top));
		endcase
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
			input logic [TIME_W-1:0] t_start, input logic [TIME_W-1:0] t_end);
		int gap;
		seg_result_t r;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{PAD_W{1'b0}}, t_end, t_start, pos};
		do @(posedge clk); while (!s_tready);
		r = apply_request(op, pos, t_start, t_end);
		expected_q.push_back(r);
		sent_total++;
		case (r.status)
			ST_DONE: done_total++;
			ST_FULL: full_total++;
			default: bad_total++;
		endcase
		if (model_count > peak_count)
			peak_count = model_count;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	task automatic send_random_request(input int phase);
		logic [OP_W-1:0] op;
		int r;
		int grow_pct;
		int shrink_pct;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send_request(OP_W'($urandom_range(0, 7)), CNT_W'($urandom_range(0, POS_MAX)),
				rand_time(), rand_time());
			return;
		end
		grow_pct = (phase == 0) ? 60 : (phase == 1) ? 15 : 30;
		shrink_pct = (phase == 1) ? 60 : (phase == 0) ? 15 : 30;
		r = $urandom_range(0, 99);
		if (r < grow_pct)
			op = $urandom_range(0, 1) ? OP_INSERT : OP_INSERT_ANTI;
		else if (r < grow_pct + shrink_pct)
			op = $urandom_range(0, 1) ? OP_REMOVE : OP_REMOVE_ANTI;
		else
			op = $urandom_range(0, 1) ? OP_MOVE : OP_READ;
		send_request(op, pick_position(op, model_count), rand_time(), rand_time());
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (hold_left == 0 && long_hold_req) begin
			hold_left = LONG_HOLD;
			long_hold_req = 1'b0;
		end else if (hold_left == 0 && idle_on && $urandom_range(0, 4) == 0)
			hold_left = $urandom_range(1, 6);
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin : result_check
		seg_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				error_count++;
				$display("%0t: result transfer with nothing expected, actual status %0d",
					$time, m_tuser);
			end else begin
				want = expected_q.pop_front();
				results_seen++;
				check_field("status", want.status, m_tuser);
				check_field("count_after", want.count_after, m_tdata[CNT_W-1:0]);
				check_field("read_start", want.read_start,
					m_tdata[START_LSB +: TIME_W]);
				check_field("read_end", want.read_end, m_tdata[END_LSB +: TIME_W]);
			end
		end
	end

	task automatic test_empty_list();
		send_request(OP_READ, '0, rand_time(), rand_time());
		send_request(OP_MOVE, '0, 32'h1234_5678, 32'h9abc_def0);
		send_request(OP_REMOVE, '0, '0, '0);
		send_request(OP_REMOVE_ANTI, '0, '0, '0);
		send_request(OP_INSERT, 7'd1, '1, '1);
		send_request(OP_SPARE_LO, '0, '0, '0);
		send_request(OP_SPARE_HI, 7'(POS_MAX), '1, '1);
	endtask

	task automatic test_wrap_and_split();
		send_request(OP_INSERT_ANTI, 7'(POS_MAX), '0, '1);
		send_request(OP_READ, '0, '0, '0);
		send_request(OP_REMOVE_ANTI, '0, '0, '0);
		send_request(OP_INSERT_ANTI, '0, 32'hc000_0000, 32'h4000_0000);
		send_request(OP_INSERT_ANTI, '0, 32'h1000_0000, 32'h2000_0000);
		send_request(OP_READ, '0, '0, '0);
		send_request(OP_READ, 7'd1, '0, '0);
		send_request(OP_INSERT, CNT_W'(model_count), 32'h8000_0000, 32'hffff_fffe);
		send_request(OP_INSERT, '0, '1, '0);
		send_request(OP_MOVE, 7'd1, 32'h5555_5555, 32'haaaa_aaaa);
		send_request(OP_REMOVE_ANTI, 7'd1, '0, '0);
		send_request(OP_REMOVE_ANTI, CNT_W'(model_count - 1), '0, '0);
		send_request(OP_READ, '0, '0, '0);
		send_request(OP_READ, 7'd1, '0, '0);
		send_request(OP_INSERT, CNT_W'(model_count + 1), '0, '0);
		send_request(OP_INSERT_ANTI, CNT_W'(model_count), '0, '0);
		send_request(OP_REMOVE, 7'd1, '0, '0);
		send_request(OP_REMOVE, '0, '0, '0);
		send_request(OP_READ, '0, '0, '0);
	endtask

	task automatic test_full_list();
		logic [OP_W-1:0] op;
		while (model_count < MAX_SEGMENTS) begin
			op = $urandom_range(0, 1) ? OP_INSERT : OP_INSERT_ANTI;
			send_request(op, pick_position(op, model_count), rand_time(), rand_time());
		end
		send_request(OP_INSERT, '0, rand_time(), rand_time());
		send_request(OP_INSERT, 7'(POS_MAX), rand_time(), rand_time());
		send_request(OP_INSERT_ANTI, '0, rand_time(), rand_time());
		send_request(OP_INSERT_ANTI, 7'(POS_MAX), rand_time(), rand_time());
		send_request(OP_READ, 7'(MAX_SEGMENTS - 1), '0, '0);
		send_request(OP_MOVE, 7'(MAX_SEGMENTS - 1), '1, '0);
		send_request(OP_READ, 7'(POS_MAX), '0, '0);
		send_request(OP_REMOVE_ANTI, 7'(MAX_SEGMENTS - 1), '0, '0);
		send_request(OP_INSERT_ANTI, CNT_W'(model_count - 1), rand_time(), rand_time());
		send_request(OP_READ, 7'(MAX_SEGMENTS - 1), '0, '0);
		send_request(OP_REMOVE, 7'(MAX_SEGMENTS - 1), '0, '0);
		send_request(OP_REMOVE, '0, '0, '0);
	endtask

	task automatic test_backpressure();
		long_hold_req = 1'b1;
		for (int i = 0; i < 100; i++)
			send_random_request(2);
		wait_drained();
	endtask

	task automatic test_random_mix(input int total);
		int phase;
		phase = 1;
		for (int i = 0; i < total; i++) begin
			if (i % 60 == 0)
				phase = $urandom_range(0, 2);
			idle_on = (i < total - 150);
			if (i % 175 == 174)
				wait_drained();
			send_random_request(phase);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_wrap_and_split();
		test_full_list();
		test_backpressure();
		test_random_mix(700);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			error_count++;
			$display("%0t: %0d expected results never arrived", $time, expected_q.size());
		end
		$display("Sent %0d requests (%0d done, %0d rejected full, %0d rejected bad), %0d checked.",
			sent_total, done_total, full_total, bad_total, results_seen);
		$display("List length peaked at %0d, with a %0d-cycle receiver hold along the way.",
			peak_count, LONG_HOLD);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
